>>> sv/serial_reply_frame_checker_defines.svh
// Assertion macros used by the reply frame checker back end.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef SERIAL_REPLY_FRAME_CHECKER_DEFINES_SVH
`define SERIAL_REPLY_FRAME_CHECKER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SRFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srfc: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define SRFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srfc: next-cycle check failed");

`endif

>>> sv/srfc_pkg.sv
// Shared types, frame constants and the CRC-8 byte update for the reply checker.
// No dependencies.
package srfc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] BYTE_REJECT    = 8'hA2;
  localparam logic [7:0] BYTE_START     = 8'hA5;
  localparam logic [7:0] BYTE_END       = 8'hA6;
  localparam logic [7:0] HIGH_XOR       = 8'h40;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd7;

  localparam logic [7:0] CRC_POLY_RESET = 8'h07;

  // Configuration register indexes
  localparam logic [1:0] CFG_CRC_POLY = 2'd0;
  localparam logic [1:0] CFG_SLAVE    = 2'd1;
  localparam logic [1:0] CFG_REG_LOW  = 2'd2;
  localparam logic [1:0] CFG_REG_HIGH = 2'd3;

  // Final status codes
  localparam logic [1:0] STATUS_GOOD   = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_FAIL   = 2'd2;

  typedef enum logic {
    ITEM_BEGIN = 1'b0,
    ITEM_BYTE  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] crc_poly;
    logic [7:0] slave_addr;
    logic [7:0] reg_low;
    logic [7:0] reg_high;
  } cfg_t;

  // MSB-first CRC-8 update over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] crc;
    logic [7:0] d;
    logic       top;
    crc = crc_in;
    d   = data;
    for (int i = 0; i < 8; i++) begin
      top = crc[7] ^ d[7];
      crc = {crc[6:0], 1'b0};
      if (top) begin
        crc = crc ^ poly;
      end
      d = {d[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

>>> sv/serial_reply_frame_checker.sv
// An accepted transaction passes through the queue and then the registered result stage.
// Throughput: one input transaction per cycle while the output is not stalled; the frame
// state machine handles one byte per cycle with a combinational CRC-8 byte update, fed by a two-entry queue.
// An output stall holds the back end; the queue then fills its two entries and stalls the input.
// Reset: synchronous, active low; empties the queue and output register, returns the
// checker to ignoring bytes until a begin, and sets polynomial 0x07, other registers 0.
module serial_reply_frame_checker
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly   <= CRC_POLY_RESET;
      cfg_r.slave_addr <= 8'd0;
      cfg_r.reg_low    <= 8'd0;
      cfg_r.reg_high   <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CRC_POLY: cfg_r.crc_poly   <= cfg_wdata;
        CFG_SLAVE:    cfg_r.slave_addr <= cfg_wdata;
        CFG_REG_LOW:  cfg_r.reg_low    <= cfg_wdata;
        CFG_REG_HIGH: cfg_r.reg_high   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  srfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  srfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_status (out_is_status),
    .out_data_byte (out_data_byte),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

>>> sv/srfc_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on srfc_pkg.
module srfc_front
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push;
  item_t             in_item;

  // Classify the incoming transaction
  assign in_item.kind    = in_op ? ITEM_BYTE : ITEM_BEGIN;
  assign in_item.rx_byte = in_rx_byte;

  assign in_stall = (count_r == CntW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !(q_pop && q_valid)) begin
      count_nxt = count_r + CntW'(1);
    end else if (!push && q_pop && q_valid) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> sv/srfc_back.sv
// Back end: frame state machine, CRC check and registered result stage.
// Depends on srfc_pkg and serial_reply_frame_checker_defines.svh.
`include "serial_reply_frame_checker_defines.svh"

module srfc_back
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_status,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_last
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_HEADER,
    PH_DATA,
    PH_CRC,
    PH_END
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       out_valid_r;
  logic       out_is_status_r;
  logic [7:0] out_data_byte_r;
  logic [1:0] out_status_r;

  logic       out_ready;
  logic       emit;
  logic       res_is_status;
  logic [7:0] res_data;
  logic [1:0] res_status;
  logic [8:0] count_inc;
  logic [7:0] b;

  assign out_ready = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && out_ready;
  assign b         = q_item.rx_byte;
  assign count_inc = {1'b0, byte_count_r} + 9'd1;

  // Next state and result for the popped transaction
  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    crc_nxt          = crc_r;
    emit             = 1'b0;
    res_is_status    = 1'b0;
    res_data         = 8'd0;
    res_status       = STATUS_GOOD;
    if (q_pop) begin
      if (q_item.kind == ITEM_BEGIN) begin
        phase_nxt        = PH_FIRST;
        byte_count_nxt   = 8'd0;
        frame_length_nxt = 8'd0;
        crc_nxt          = 8'd0;
      end else begin
        case (phase_r)
          PH_FIRST: begin
            if (b == BYTE_REJECT) begin
              emit          = 1'b1;
              res_is_status = 1'b1;
              res_status    = STATUS_REJECT;
              phase_nxt     = PH_IDLE;
            end else if (b == BYTE_START) begin
              phase_nxt      = PH_HEADER;
              byte_count_nxt = 8'd0;
              crc_nxt        = 8'd0;
            end else begin
              emit          = 1'b1;
              res_is_status = 1'b1;
              res_status    = STATUS_FAIL;
              phase_nxt     = PH_IDLE;
            end
          end
          PH_HEADER: begin
            // crc_r holds a mismatch flag while the header is checked
            if (byte_count_r == 8'd0) begin
              if (b != cfg.slave_addr) crc_nxt = 8'd1;
              byte_count_nxt = count_inc[7:0];
            end else if (byte_count_r == 8'd1) begin
              if (b != cfg.reg_low) crc_nxt = 8'd1;
              byte_count_nxt = count_inc[7:0];
            end else if (byte_count_r == 8'd2) begin
              if ((b ^ cfg.reg_high) != HIGH_XOR) crc_nxt = 8'd1;
              byte_count_nxt = count_inc[7:0];
            end else begin
              // length byte
              if (crc_r != 8'd0 || b < FRAME_OVERHEAD) begin
                emit          = 1'b1;
                res_is_status = 1'b1;
                res_status    = STATUS_FAIL;
                phase_nxt     = PH_IDLE;
              end else begin
                frame_length_nxt = b - FRAME_OVERHEAD;
                byte_count_nxt   = 8'd0;
                crc_nxt          = 8'd0;
                phase_nxt        = (b == FRAME_OVERHEAD) ? PH_CRC : PH_DATA;
              end
            end
          end
          PH_DATA: begin
            crc_nxt        = crc8_update(crc_r, b, cfg.crc_poly);
            byte_count_nxt = count_inc[7:0];
            if (count_inc >= {1'b0, frame_length_r}) begin
              phase_nxt = PH_CRC;
            end
            emit     = 1'b1;
            res_data = b;
          end
          PH_CRC: begin
            crc_nxt   = crc_r ^ b;
            phase_nxt = PH_END;
          end
          PH_END: begin
            emit          = 1'b1;
            res_is_status = 1'b1;
            res_status    = (crc_r == 8'd0 && b == BYTE_END) ? STATUS_GOOD : STATUS_FAIL;
            phase_nxt     = PH_IDLE;
          end
          default: begin
            // ignoring bytes until a begin transaction
          end
        endcase
      end
    end
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= 8'd0;
      frame_length_r <= 8'd0;
      crc_r          <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      crc_r          <= crc_nxt;
      if (out_ready) begin
        out_valid_r <= q_pop && emit;
      end
      if (q_pop && emit) begin
        out_is_status_r <= res_is_status;
        out_data_byte_r <= res_data;
        out_status_r    <= res_status;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_status = out_is_status_r;
  assign out_data_byte = out_data_byte_r;
  assign out_status    = out_status_r;
  assign out_last      = out_is_status_r;

  // Checks
  `SRFC_ASSERT_NEXT(a_begin_rearms, q_pop && q_item.kind == ITEM_BEGIN,
                    phase_r == PH_FIRST && crc_r == 8'd0)
  `SRFC_ASSERT_NEXT(a_end_goes_idle, q_pop && q_item.kind == ITEM_BYTE && phase_r == PH_END,
                    phase_r == PH_IDLE && out_valid_r && out_is_status_r)
  `SRFC_ASSERT_NEXT(a_result_held, out_valid_r && out_stall,
                    out_valid_r && $stable(out_data_byte_r) && $stable(out_status_r))
  `SRFC_ASSERT_NOW(a_data_status_zero, out_valid_r && !out_is_status_r,
                   out_status_r == STATUS_GOOD)

endmodule
